@@ src/sdc_pkg.sv @@
// Shared constants, codes and types of the stepper step/direction controller.
package sdc_pkg;

  // Operand widths of the period divider
  localparam int unsigned DIVIDEND_W = 24;
  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Command codes
  localparam logic [4:0] FN_TICK        = 5'd0;
  localparam logic [4:0] FN_GET_POS     = 5'd1;
  localparam logic [4:0] FN_SET_POS_SP  = 5'd2;
  localparam logic [4:0] FN_GET_POS_SP  = 5'd3;
  localparam logic [4:0] FN_SET_VEL_SP  = 5'd4;
  localparam logic [4:0] FN_GET_VEL_SP  = 5'd5;
  localparam logic [4:0] FN_GET_VEL     = 5'd6;
  localparam logic [4:0] FN_SET_DIR_SP  = 5'd7;
  localparam logic [4:0] FN_GET_DIR_SP  = 5'd8;
  localparam logic [4:0] FN_SET_MODE    = 5'd9;
  localparam logic [4:0] FN_GET_MODE    = 5'd10;
  localparam logic [4:0] FN_SET_POS_VEL = 5'd11;
  localparam logic [4:0] FN_GET_POS_VEL = 5'd12;
  localparam logic [4:0] FN_GET_POS_ERR = 5'd13;
  localparam logic [4:0] FN_SET_ZERO    = 5'd14;
  localparam logic [4:0] FN_GET_MAX_VEL = 5'd15;
  localparam logic [4:0] FN_GET_MIN_VEL = 5'd16;
  localparam logic [4:0] FN_GET_STATUS  = 5'd17;
  localparam logic [4:0] FN_SET_STATUS  = 5'd18;
  localparam logic [4:0] FN_GET_DIR     = 5'd19;
  localparam logic [4:0] FN_TEST        = 5'd20;

  // Reply data kinds
  localparam logic [1:0] KIND_S32  = 2'd0;
  localparam logic [1:0] KIND_U16  = 2'd1;
  localparam logic [1:0] KIND_U8   = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_CLK_HZ  = 3'd0;
  localparam logic [2:0] CFG_TOP_MIN = 3'd1;
  localparam logic [2:0] CFG_TOP_MAX = 3'd2;
  localparam logic [2:0] CFG_MAX_VEL = 3'd3;
  localparam logic [2:0] CFG_MIN_VEL = 3'd4;

  // Configuration reset values
  localparam logic [23:0] CLK_HZ_RST  = 24'd2000000;
  localparam logic [15:0] TOP_MIN_RST = 16'd100;
  localparam logic [15:0] TOP_MAX_RST = 16'd20000;
  localparam logic [15:0] MAX_VEL_RST = 16'd19801;
  localparam logic [15:0] MIN_VEL_RST = 16'd99;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ src/sdc_div.sv @@
// Restoring bit-serial divider for the step period top, one quotient bit per cycle.
module sdc_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [sdc_pkg::DIVIDEND_W-1:0]        dividend_i,
  input  logic [sdc_pkg::DIVISOR_W-1:0]         divisor_i,
  output logic [sdc_pkg::DIVIDEND_W-1:0]        quotient_o,
  output sdc_pkg::div_stat_t                    stat_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [sdc_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [sdc_pkg::DIVISOR_W-1:0]      rem_q, rem_d;
  logic [sdc_pkg::DIVISOR_W-1:0]      dvs_q, dvs_d;
  logic [sdc_pkg::DIVIDEND_W-1:0]     quo_q, quo_d;
  logic [sdc_pkg::DIVISOR_W:0]        trial;
  logic [sdc_pkg::DIVISOR_W:0]        diff;
  logic                               ge;

  // One trial subtraction per cycle
  assign trial = {rem_q, quo_q[sdc_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[sdc_pkg::DIVISOR_W-1:0] : trial[sdc_pkg::DIVISOR_W-1:0];
      quo_d = {quo_q[sdc_pkg::DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == sdc_pkg::DIV_CNT_W'(sdc_pkg::DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ src/stepper_step_dir_controller.sv @@
// Stepper step/direction controller: command decode, drive rule sequencer and outputs.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per command or step
//   tick: func_i selects the action, value_i holds its argument. Output channel
//   (out_valid_o / out_stall_i) returns exactly one beat per input beat with the
//   echoed code, the reply and the drive outputs as they stand after the item.
//   A beat moves on a rising edge with valid high and stall low.
//   A tick goes from the idle state straight to the output state. A command
//   passes the mode rule, the 24-step serial divider that computes the period
//   top floor(step_clock_hz / velocity) - 1 and the clamp, then the output
//   state; divider and clamp are skipped when the drive velocity is 0.
//   One item is in work at a time; in_stall_o stays high until its result has
//   been loaded into the output register, so no new item is accepted before
//   then. The output register holds its beat while out_stall_i is high; a new
//   result waits in the sequencer until that register frees up.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i at once;
//   write only while idle. A write does not recompute the period top.
//   Reset (rst_ni low, asynchronous) restores the register defaults, clears all
//   positions and set-points, stops the motor and sets the period top to 20000.
module stepper_step_dir_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  func_i,
  input  logic signed [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  echo_func_o,
  output logic [1:0]  data_kind_o,
  output logic signed [31:0] reply_data_o,
  output logic        step_enable_o,
  output logic        dir_out_o,
  output logic [15:0] period_top_o,
  output logic [14:0] pulse_compare_o,
  output logic        vel_trigger_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RULE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CLAMP = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state_q, state_d;

  // Configuration registers
  logic [23:0] clk_hz_q;
  logic [15:0] top_min_q, top_max_q, max_vel_q, min_vel_q;

  // Controller state
  logic [31:0] pos_q, pos_d, pos_sp_q, pos_sp_d;
  logic [15:0] vel_sp_q, vel_sp_d, pos_vel_q, pos_vel_d, drv_vel_q, drv_vel_d;
  logic        dir_sp_q, dir_sp_d, mode_vel_q, mode_vel_d, run_q, run_d;
  logic        drv_dir_q, drv_dir_d, en_q, en_d, trig_q, trig_d;
  logic [15:0] top_q, top_d;

  // Item in work
  logic [4:0]  func_q, func_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] reply_q, reply_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [4:0]  o_func_q;
  logic [1:0]  o_kind_q;
  logic [31:0] o_reply_q;
  logic        o_en_q, o_dir_q, o_trig_q;
  logic [15:0] o_top_q;

  // Helpers
  logic        in_acc, out_load, div_start;
  logic [31:0] v32, pos_step, err;
  logic [15:0] v16, v16_clamp;
  logic        v8_ok;
  logic [23:0] quotient, qm1, lo24;
  logic        raise;
  sdc_pkg::div_stat_t div_stat;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign v32       = value_i;
  assign v16       = v32[15:0];
  assign v8_ok     = (v32[7:1] == 7'd0);
  assign v16_clamp = (v16 < max_vel_q) ? v16 : max_vel_q;
  assign pos_step  = drv_dir_q ? (pos_q - 32'd1) : (pos_q + 32'd1);
  assign err       = pos_sp_q - pos_q;

  // Period top clamp: raise to top_min, then lower to top_max
  assign qm1   = quotient - 24'd1;
  assign raise = (quotient == 24'd0) || (qm1 < {8'd0, top_min_q});
  assign lo24  = raise ? {8'd0, top_min_q} : qm1;

  // Sequencer and state update
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    pos_sp_d   = pos_sp_q;
    vel_sp_d   = vel_sp_q;
    pos_vel_d  = pos_vel_q;
    drv_vel_d  = drv_vel_q;
    dir_sp_d   = dir_sp_q;
    mode_vel_d = mode_vel_q;
    run_d      = run_q;
    drv_dir_d  = drv_dir_q;
    en_d       = en_q;
    trig_d     = trig_q;
    top_d      = top_q;
    func_d     = func_q;
    kind_d     = kind_q;
    reply_d    = reply_q;
    div_start  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d  = func_i;
          kind_d  = sdc_pkg::KIND_NONE;
          reply_d = 32'd0;
          state_d = S_RULE;
          unique case (func_i)
            sdc_pkg::FN_TICK: begin
              state_d = S_OUT;
              if (run_q && (drv_vel_q != 16'd0)) begin
                pos_d = pos_step;
                if (!mode_vel_q && (pos_step == pos_sp_q)) begin
                  en_d      = 1'b0;
                  drv_vel_d = 16'd0;
                end
              end
            end
            sdc_pkg::FN_GET_POS: begin
              kind_d = sdc_pkg::KIND_S32; reply_d = pos_q;
            end
            sdc_pkg::FN_SET_POS_SP: begin
              pos_sp_d = v32; kind_d = sdc_pkg::KIND_S32; reply_d = v32;
            end
            sdc_pkg::FN_GET_POS_SP: begin
              kind_d = sdc_pkg::KIND_S32; reply_d = pos_sp_q;
            end
            sdc_pkg::FN_SET_VEL_SP: begin
              vel_sp_d = v16_clamp; kind_d = sdc_pkg::KIND_U16;
              reply_d  = {16'd0, v16_clamp};
            end
            sdc_pkg::FN_GET_VEL_SP: begin
              kind_d = sdc_pkg::KIND_U16; reply_d = {16'd0, vel_sp_q};
            end
            sdc_pkg::FN_GET_VEL: begin
              kind_d = sdc_pkg::KIND_U16; reply_d = {16'd0, drv_vel_q};
            end
            sdc_pkg::FN_SET_DIR_SP: begin
              kind_d = sdc_pkg::KIND_U8;
              if (v8_ok) begin
                dir_sp_d = v32[0]; reply_d = {31'd0, v32[0]};
              end else begin
                reply_d = {31'd0, dir_sp_q};
              end
            end
            sdc_pkg::FN_GET_DIR_SP: begin
              kind_d = sdc_pkg::KIND_U8; reply_d = {31'd0, dir_sp_q};
            end
            sdc_pkg::FN_SET_MODE: begin
              kind_d = sdc_pkg::KIND_U8;
              if (v8_ok) begin
                mode_vel_d = v32[0]; reply_d = {31'd0, v32[0]};
              end else begin
                reply_d = {31'd0, mode_vel_q};
              end
            end
            sdc_pkg::FN_GET_MODE: begin
              kind_d = sdc_pkg::KIND_U8; reply_d = {31'd0, mode_vel_q};
            end
            sdc_pkg::FN_SET_POS_VEL: begin
              pos_vel_d = v16_clamp; kind_d = sdc_pkg::KIND_U16;
              reply_d   = {16'd0, v16_clamp};
            end
            sdc_pkg::FN_GET_POS_VEL: begin
              kind_d = sdc_pkg::KIND_U16; reply_d = {16'd0, pos_vel_q};
            end
            sdc_pkg::FN_GET_POS_ERR: begin
              kind_d = sdc_pkg::KIND_S32; reply_d = err;
            end
            sdc_pkg::FN_SET_ZERO: begin
              // shift the origin: both position and set-point move by value
              pos_sp_d = pos_sp_q - v32;
              pos_d    = pos_q - v32;
              kind_d   = sdc_pkg::KIND_S32;
            end
            sdc_pkg::FN_GET_MAX_VEL: begin
              kind_d = sdc_pkg::KIND_U16; reply_d = {16'd0, max_vel_q};
            end
            sdc_pkg::FN_GET_MIN_VEL: begin
              kind_d = sdc_pkg::KIND_U16; reply_d = {16'd0, min_vel_q};
            end
            sdc_pkg::FN_GET_STATUS: begin
              kind_d = sdc_pkg::KIND_U8; reply_d = {31'd0, run_q};
            end
            sdc_pkg::FN_SET_STATUS: begin
              kind_d = sdc_pkg::KIND_U8;
              if (v8_ok) begin
                run_d = v32[0]; reply_d = {31'd0, v32[0]};
              end else begin
                reply_d = {31'd0, run_q};
              end
            end
            sdc_pkg::FN_GET_DIR: begin
              kind_d = sdc_pkg::KIND_U8; reply_d = {31'd0, drv_dir_q};
            end
            sdc_pkg::FN_TEST: begin
              kind_d = sdc_pkg::KIND_U8; reply_d = 32'd1;
            end
            default: begin
              kind_d = sdc_pkg::KIND_NONE;
            end
          endcase
        end
      end
      S_RULE: begin
        // Mode rule: drive velocity, direction and enables
        if (mode_vel_q) begin
          drv_dir_d = dir_sp_q;
          if (run_q && (vel_sp_q > min_vel_q)) begin
            drv_vel_d = vel_sp_q; en_d = 1'b1; trig_d = 1'b1;
          end else begin
            drv_vel_d = 16'd0; en_d = 1'b0; trig_d = 1'b0;
          end
        end else begin
          drv_dir_d = !((err != 32'd0) && !err[31]);
          if ((err != 32'd0) && run_q) begin
            drv_vel_d = pos_vel_q; en_d = 1'b1;
          end else begin
            drv_vel_d = 16'd0; en_d = 1'b0;
          end
        end
        if (drv_vel_d == 16'd0) begin
          top_d   = top_max_q;
          state_d = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) state_d = S_CLAMP;
      end
      S_CLAMP: begin
        top_d   = (lo24 > {8'd0, top_max_q}) ? top_max_q : lo24[15:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  sdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clk_hz_q),
    .divisor_i  (drv_vel_d),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q  <= sdc_pkg::CLK_HZ_RST;
      top_min_q <= sdc_pkg::TOP_MIN_RST;
      top_max_q <= sdc_pkg::TOP_MAX_RST;
      max_vel_q <= sdc_pkg::MAX_VEL_RST;
      min_vel_q <= sdc_pkg::MIN_VEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sdc_pkg::CFG_CLK_HZ:  clk_hz_q  <= cfg_data_i;
        sdc_pkg::CFG_TOP_MIN: top_min_q <= cfg_data_i[15:0];
        sdc_pkg::CFG_TOP_MAX: top_max_q <= cfg_data_i[15:0];
        sdc_pkg::CFG_MAX_VEL: max_vel_q <= cfg_data_i[15:0];
        sdc_pkg::CFG_MIN_VEL: min_vel_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Controller state and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      pos_sp_q    <= '0;
      vel_sp_q    <= '0;
      pos_vel_q   <= '0;
      drv_vel_q   <= '0;
      dir_sp_q    <= 1'b0;
      mode_vel_q  <= 1'b0;
      run_q       <= 1'b0;
      drv_dir_q   <= 1'b0;
      en_q        <= 1'b0;
      trig_q      <= 1'b0;
      top_q       <= sdc_pkg::TOP_MAX_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      pos_sp_q    <= pos_sp_d;
      vel_sp_q    <= vel_sp_d;
      pos_vel_q   <= pos_vel_d;
      drv_vel_q   <= drv_vel_d;
      dir_sp_q    <= dir_sp_d;
      mode_vel_q  <= mode_vel_d;
      run_q       <= run_d;
      drv_dir_q   <= drv_dir_d;
      en_q        <= en_d;
      trig_q      <= trig_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item and output payload
  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    kind_q  <= kind_d;
    reply_q <= reply_d;
    if (out_load) begin
      o_func_q  <= func_q;
      o_kind_q  <= kind_q;
      o_reply_q <= reply_q;
      o_en_q    <= en_q;
      o_dir_q   <= drv_dir_q;
      o_trig_q  <= trig_q;
      o_top_q   <= top_q;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign echo_func_o     = o_func_q;
  assign data_kind_o     = o_kind_q;
  assign reply_data_o    = o_reply_q;
  assign step_enable_o   = o_en_q;
  assign dir_out_o       = o_dir_q;
  assign period_top_o    = o_top_q;
  assign pulse_compare_o = o_top_q[15:1];
  assign vel_trigger_o   = o_trig_q;

`ifndef SYNTHESIS
  // An accepted beat always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after accepting a beat");

  // Divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("divider done outside the divide state");

  // While waiting on the divider it is busy or just finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> (div_stat.busy || div_stat.done))
    else $error("divide state without an active divider");
`endif

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the stepper step/direction controller.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  // Drain time before a register write, from the command latency
  localparam int unsigned SETTLE_CYCLES = 32;

  // One predicted output beat
  typedef struct packed {
    logic [4:0]  func;
    logic [1:0]  kind;
    logic [31:0] data;
    logic        en;
    logic        dir;
    logic [15:0] top;
    logic [14:0] pulse;
    logic        trig;
  } reply_t;

  // DUT connections; the inputs driven here are known from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = sdc_pkg::CFG_CLK_HZ;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [4:0]  func = sdc_pkg::FN_TICK;
  logic [31:0] value = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [4:0]  echo_func_o;
  logic [1:0]  data_kind_o;
  logic signed [31:0] reply_data_o;
  logic        step_enable_o;
  logic        dir_out_o;
  logic [15:0] period_top_o;
  logic [14:0] pulse_compare_o;
  logic        vel_trigger_o;

  stepper_step_dir_controller u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .func_i          (func),
    .value_i         (value),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .echo_func_o     (echo_func_o),
    .data_kind_o     (data_kind_o),
    .reply_data_o    (reply_data_o),
    .step_enable_o   (step_enable_o),
    .dir_out_o       (dir_out_o),
    .period_top_o    (period_top_o),
    .pulse_compare_o (pulse_compare_o),
    .vel_trigger_o   (vel_trigger_o)
  );

  // Clock: 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Register shadow
  logic [23:0] cfg_clk_hz  = sdc_pkg::CLK_HZ_RST;
  logic [15:0] cfg_top_min = sdc_pkg::TOP_MIN_RST;
  logic [15:0] cfg_top_max = sdc_pkg::TOP_MAX_RST;
  logic [15:0] cfg_max_vel = sdc_pkg::MAX_VEL_RST;
  logic [15:0] cfg_min_vel = sdc_pkg::MIN_VEL_RST;

  // Controller state as predicted
  logic [31:0] pos_st   = '0;
  logic [31:0] pos_sp   = '0;
  logic [15:0] vel_sp   = '0;
  logic        dir_sp   = 1'b0;
  logic        mode_vel = 1'b0;
  logic [15:0] pos_vel  = '0;
  logic        run_st   = 1'b0;
  logic [15:0] drv_vel  = '0;
  logic        drv_dir  = 1'b0;
  logic        drv_en   = 1'b0;
  logic        trig_lvl = 1'b0;
  logic [15:0] top_reg  = sdc_pkg::TOP_MAX_RST;

  reply_t      replies_due[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 1;
  int unsigned moving_ticks = 0;
  int unsigned arrivals = 0;
  int unsigned cycle_cnt = 0;

  // Idle percentages of both sides
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // Receiver hold-off request, served by the stall process
  int unsigned hold_len = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  // Period top: floor(clock / vel) - 1, raised to top_min, then lowered to top_max
  function automatic logic [15:0] period_top_for(input logic [15:0] vel);
    longint t;
    longint lo;
    longint hi;
    lo = cfg_top_min;
    hi = cfg_top_max;
    if (vel == 16'd0) t = hi;
    else t = longint'(cfg_clk_hz / vel) - 1;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    return t[15:0];
  endfunction

  function automatic logic [15:0] clamp_vel(input logic [15:0] v);
    return (v < cfg_max_vel) ? v : cfg_max_vel;
  endfunction

  // Advance the predicted controller by one item and form its reply beat
  task automatic compute_reply(input logic [4:0] fn, input logic [31:0] v, output reply_t r);
    logic [15:0] v16;
    logic [7:0]  v8;
    logic [1:0]  kind;
    logic [31:0] data;
    logic [31:0] err;
    v16  = v[15:0];
    v8   = v[7:0];
    kind = sdc_pkg::KIND_NONE;
    data = '0;
    if (fn == sdc_pkg::FN_TICK) begin
      // Step only while running with a nonzero drive velocity
      if (run_st && drv_vel != 16'd0) begin
        pos_st = drv_dir ? pos_st - 32'd1 : pos_st + 32'd1;
        moving_ticks++;
        if (!mode_vel && pos_st == pos_sp) begin
          drv_en  = 1'b0;
          drv_vel = '0;
          arrivals++;
        end
      end
    end else begin
      // Gets read state before the mode rule
      case (fn)
        sdc_pkg::FN_GET_POS: begin
          kind = sdc_pkg::KIND_S32; data = pos_st;
        end
        sdc_pkg::FN_SET_POS_SP: begin
          pos_sp = v; kind = sdc_pkg::KIND_S32; data = pos_sp;
        end
        sdc_pkg::FN_GET_POS_SP: begin
          kind = sdc_pkg::KIND_S32; data = pos_sp;
        end
        sdc_pkg::FN_SET_VEL_SP: begin
          vel_sp = clamp_vel(v16); kind = sdc_pkg::KIND_U16; data = vel_sp;
        end
        sdc_pkg::FN_GET_VEL_SP: begin
          kind = sdc_pkg::KIND_U16; data = vel_sp;
        end
        sdc_pkg::FN_GET_VEL: begin
          kind = sdc_pkg::KIND_U16; data = drv_vel;
        end
        sdc_pkg::FN_SET_DIR_SP: begin
          if (v8 <= 8'd1) dir_sp = v8[0];
          kind = sdc_pkg::KIND_U8; data = dir_sp;
        end
        sdc_pkg::FN_GET_DIR_SP: begin
          kind = sdc_pkg::KIND_U8; data = dir_sp;
        end
        sdc_pkg::FN_SET_MODE: begin
          if (v8 <= 8'd1) mode_vel = v8[0];
          kind = sdc_pkg::KIND_U8; data = mode_vel;
        end
        sdc_pkg::FN_GET_MODE: begin
          kind = sdc_pkg::KIND_U8; data = mode_vel;
        end
        sdc_pkg::FN_SET_POS_VEL: begin
          pos_vel = clamp_vel(v16); kind = sdc_pkg::KIND_U16; data = pos_vel;
        end
        sdc_pkg::FN_GET_POS_VEL: begin
          kind = sdc_pkg::KIND_U16; data = pos_vel;
        end
        sdc_pkg::FN_GET_POS_ERR: begin
          kind = sdc_pkg::KIND_S32; data = pos_sp - pos_st;
        end
        sdc_pkg::FN_SET_ZERO: begin
          pos_sp = pos_sp - v;
          pos_st = pos_st - v;
          kind = sdc_pkg::KIND_S32; data = '0;
        end
        sdc_pkg::FN_GET_MAX_VEL: begin
          kind = sdc_pkg::KIND_U16; data = cfg_max_vel;
        end
        sdc_pkg::FN_GET_MIN_VEL: begin
          kind = sdc_pkg::KIND_U16; data = cfg_min_vel;
        end
        sdc_pkg::FN_GET_STATUS: begin
          kind = sdc_pkg::KIND_U8; data = run_st;
        end
        sdc_pkg::FN_SET_STATUS: begin
          if (v8 <= 8'd1) run_st = v8[0];
          kind = sdc_pkg::KIND_U8; data = run_st;
        end
        sdc_pkg::FN_GET_DIR: begin
          kind = sdc_pkg::KIND_U8; data = drv_dir;
        end
        sdc_pkg::FN_TEST: begin
          kind = sdc_pkg::KIND_U8; data = 32'd1;
        end
        default: ;
      endcase
      // Mode rule, then the period top
      if (mode_vel) begin
        drv_dir = dir_sp;
        if (run_st && vel_sp > cfg_min_vel) begin
          drv_vel = vel_sp; drv_en = 1'b1; trig_lvl = 1'b1;
        end else begin
          drv_vel = '0; drv_en = 1'b0; trig_lvl = 1'b0;
        end
      end else begin
        err = pos_sp - pos_st;
        drv_dir = !(err != 32'd0 && !err[31]);
        if (err != 32'd0 && run_st) begin
          drv_en = 1'b1; drv_vel = pos_vel;
        end else begin
          drv_en = 1'b0; drv_vel = '0;
        end
      end
      top_reg = period_top_for(drv_vel);
    end
    r.func  = fn;
    r.kind  = kind;
    r.data  = data;
    r.en    = drv_en;
    r.dir   = drv_dir;
    r.top   = top_reg;
    r.pulse = top_reg[15:1];
    r.trig  = trig_lvl;
  endtask

  // Send one beat, with random sender gaps, and queue its predicted reply
  task automatic send_item(input logic [4:0] fn, input logic [31:0] v);
    reply_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func     <= fn;
    value    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    compute_reply(fn, v, r);
    replies_due.push_back(r);
    items_sent++;
  endtask

  // Sender pause: every reply back, then let the sequencer settle
  task automatic wait_all_replies();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk_i);
  endtask

  // Write all five registers while idle
  task automatic load_config(input logic [23:0] clk_hz, input logic [15:0] tmin,
                             input logic [15:0] tmax, input logic [15:0] vmax,
                             input logic [15:0] vmin);
    wait_all_replies();
    write_reg(sdc_pkg::CFG_CLK_HZ, clk_hz);
    write_reg(sdc_pkg::CFG_TOP_MIN, {8'd0, tmin});
    write_reg(sdc_pkg::CFG_TOP_MAX, {8'd0, tmax});
    write_reg(sdc_pkg::CFG_MAX_VEL, {8'd0, vmax});
    write_reg(sdc_pkg::CFG_MIN_VEL, {8'd0, vmin});
    cfg_we      <= 1'b0;
    cfg_clk_hz  = clk_hz;
    cfg_top_min = tmin;
    cfg_top_max = tmax;
    cfg_max_vel = vmax;
    cfg_min_vel = vmin;
    settings_used++;
  endtask

  // Argument for code-like commands: mostly valid low byte, mostly random upper bits
  function automatic logic [31:0] rand_code_arg();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: v = $urandom_range(0, 2);
      1: v[7:0] = 8'($urandom_range(0, 1));
      2: v[7:0] = 8'($urandom_range(0, 3));
      default: ;
    endcase
    return v;
  endfunction

  // Velocity argument: small, near min_vel, or anything in 16 bits
  function automatic logic [31:0] rand_vel_arg();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: v[15:0] = 16'($urandom_range(0, 2000));
      1: v[15:0] = cfg_min_vel + 16'($urandom_range(0, 2)) - 16'd1;
      2: v[15:0] = 16'($urandom_range(1, 300));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_random_get();
    logic [4:0] gets [12];
    gets = '{sdc_pkg::FN_GET_POS, sdc_pkg::FN_GET_POS_SP, sdc_pkg::FN_GET_VEL_SP,
             sdc_pkg::FN_GET_VEL, sdc_pkg::FN_GET_DIR_SP, sdc_pkg::FN_GET_MODE,
             sdc_pkg::FN_GET_POS_VEL, sdc_pkg::FN_GET_POS_ERR, sdc_pkg::FN_GET_MAX_VEL,
             sdc_pkg::FN_GET_MIN_VEL, sdc_pkg::FN_GET_STATUS, sdc_pkg::FN_GET_DIR};
    send_item(gets[$urandom_range(11)], $urandom);
  endtask

  task automatic send_ticks(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) send_random_get();
      send_item(sdc_pkg::FN_TICK, $urandom);
    end
  endtask

  // Well-formed positioning move toward a nearby set-point
  task automatic seq_position_move();
    int offset;
    offset = int'($urandom_range(0, 12)) - 6;
    send_item(sdc_pkg::FN_SET_MODE,
              {$urandom_range(0, 1) == 0 ? 24'd0 : 24'($urandom), 8'd0});
    send_item(sdc_pkg::FN_SET_POS_VEL, rand_vel_arg());
    send_item(sdc_pkg::FN_SET_STATUS, ($urandom_range(9) == 0) ? rand_code_arg() : 32'd1);
    if ($urandom_range(7) == 0) send_item(sdc_pkg::FN_SET_POS_SP, $urandom);
    else send_item(sdc_pkg::FN_SET_POS_SP, pos_st + 32'(offset));
    send_ticks($urandom_range(0, 12));
    if ($urandom_range(3) == 0)
      send_item(sdc_pkg::FN_SET_ZERO, $urandom_range(0, 1) ? $urandom : 32'd0);
  endtask

  // Well-formed velocity run
  task automatic seq_velocity_move();
    send_item(sdc_pkg::FN_SET_MODE, 32'd1);
    send_item(sdc_pkg::FN_SET_VEL_SP, rand_vel_arg());
    send_item(sdc_pkg::FN_SET_DIR_SP, rand_code_arg());
    send_item(sdc_pkg::FN_SET_STATUS, ($urandom_range(9) == 0) ? rand_code_arg() : 32'd1);
    send_ticks($urandom_range(0, 10));
    if ($urandom_range(2) == 0) send_item(sdc_pkg::FN_SET_STATUS, 32'd0);
  endtask

  // Anything at all, including unused codes
  task automatic send_noise_item();
    logic [4:0] fn;
    fn = 5'($urandom_range(0, 31));
    send_item(fn, $urandom_range(0, 1) ? rand_code_arg() : $urandom);
  endtask

  task automatic run_random_items(input int unsigned n);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: seq_position_move();
        4, 5, 6:    seq_velocity_move();
        default:    send_noise_item();
      endcase
    end
  endtask

  // Directed: all but GET_POS_SP, field extremes, bad codes, wrap, stop at set-point
  task automatic test_directed_commands();
    send_item(sdc_pkg::FN_TICK, 32'hFFFF_FFFF);
    send_item(sdc_pkg::FN_TEST, 32'd0);
    send_item(sdc_pkg::FN_GET_MAX_VEL, 32'd0);
    send_item(sdc_pkg::FN_GET_MIN_VEL, 32'd0);
    send_item(sdc_pkg::FN_SET_POS_VEL, 32'hFFFF_FFFF);
    send_item(sdc_pkg::FN_GET_POS_VEL, 32'd0);
    send_item(sdc_pkg::FN_SET_STATUS, 32'd1);
    send_item(sdc_pkg::FN_SET_POS_SP, 32'd3);
    send_item(sdc_pkg::FN_TICK, 32'd0);
    send_item(sdc_pkg::FN_GET_POS_ERR, 32'd0);
    send_item(sdc_pkg::FN_TICK, 32'd0);
    send_item(sdc_pkg::FN_TICK, 32'd0);
    send_item(sdc_pkg::FN_TICK, 32'd0);
    send_item(sdc_pkg::FN_SET_POS_SP, 32'h8000_0000);
    send_item(sdc_pkg::FN_SET_ZERO, 32'h8000_0000);
    send_item(sdc_pkg::FN_GET_POS, 32'd0);
    send_item(sdc_pkg::FN_SET_POS_SP, 32'h7FFF_FFFF);
    send_item(sdc_pkg::FN_SET_STATUS, 32'd2);
    send_item(sdc_pkg::FN_GET_STATUS, 32'd0);
    send_item(sdc_pkg::FN_SET_DIR_SP, 32'd1);
    send_item(sdc_pkg::FN_SET_DIR_SP, 32'hFFFF_FF07);
    send_item(sdc_pkg::FN_GET_DIR_SP, 32'd0);
    send_item(sdc_pkg::FN_SET_MODE, 32'hFFFF_FF01);
    send_item(sdc_pkg::FN_SET_VEL_SP, 32'hFFFF_0063);
    send_item(sdc_pkg::FN_SET_VEL_SP, 32'h0000_0064);
    send_item(sdc_pkg::FN_TICK, 32'd0);
    send_item(sdc_pkg::FN_GET_VEL, 32'd0);
    send_item(sdc_pkg::FN_GET_DIR, 32'd0);
    send_item(sdc_pkg::FN_SET_VEL_SP, 32'h7FFF_0000);
    send_item(sdc_pkg::FN_GET_VEL_SP, 32'd0);
    send_item(sdc_pkg::FN_SET_MODE, 32'd3);
    send_item(sdc_pkg::FN_GET_MODE, 32'd0);
    send_item(5'd21, 32'h5555_5555);
    send_item(5'd31, 32'hAAAA_AAAA);
  endtask

  // Register extremes: widest range, top_min above top_max, zero clock
  task automatic test_register_extremes();
    load_config(24'd16000000, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
    run_random_items(40);
    load_config(24'd1, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF);
    run_random_items(40);
    load_config(24'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
    run_random_items(40);
    load_config(24'd16000000, 16'd300, 16'd200, 16'd40000, 16'd1);
    run_random_items(40);
    load_config(sdc_pkg::CLK_HZ_RST, sdc_pkg::TOP_MIN_RST, sdc_pkg::TOP_MAX_RST,
                sdc_pkg::MAX_VEL_RST, sdc_pkg::MIN_VEL_RST);
  endtask

  // Random traffic over three idle profiles, new random registers per chunk after the first
  task automatic test_random_traffic();
    int unsigned tx_pct [3];
    int unsigned rx_pct [3];
    tx_pct = '{7, 73, 0};
    rx_pct = '{73, 7, 0};
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_idle_pct = rx_pct[p];
      for (int c = 0; c < 4; c++) begin
        if (p != 0 || c != 0) begin
          load_config(24'($urandom_range(0, 1) ? $urandom_range(1, 16000000)
                                               : $urandom_range(1, 4000000)),
                      16'($urandom_range(1, 600)),
                      16'($urandom_range(0, 3) == 0 ? $urandom_range(1, 65535)
                                                    : $urandom_range(2000, 65535)),
                      16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 3000)),
                      16'($urandom_range(0, 400)));
        end
        run_random_items(120);
      end
    end
  endtask

  // Receiver holds off long while the sender keeps offering beats
  task automatic test_output_hold_off();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_len = 500;
    hold_req++;
    run_random_items(30);
    wait_all_replies();
  endtask

  // Sender stops mid-stream until every reply is back, then resumes
  task automatic test_sender_pause();
    tx_idle_pct = 7;
    rx_idle_pct = 7;
    run_random_items(20);
    wait_all_replies();
    run_random_items(20);
  endtask

  // Receiver stall: random, or a counted hold-off
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [4:0] fn,
                                      input logic [31:0] exp, input logic [31:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch on func %0d: expected %0h, actual %0h",
               $time, name, fn, exp, act);
      mismatches++;
    end
  endfunction

  // Compare each delivered beat with the oldest prediction
  always @(posedge clk_i) begin : check_replies
    reply_t exp;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (replies_due.size() == 0) begin
        $display("%0t: reply beat with nothing expected, func %0d", $time, echo_func_o);
        mismatches++;
      end else begin
        exp = replies_due.pop_front();
        check_field("echo_func", exp.func, exp.func, echo_func_o);
        check_field("data_kind", exp.func, exp.kind, data_kind_o);
        check_field("reply_data", exp.func, exp.data, reply_data_o);
        check_field("step_enable", exp.func, exp.en, step_enable_o);
        check_field("dir_out", exp.func, exp.dir, dir_out_o);
        check_field("period_top", exp.func, exp.top, period_top_o);
        check_field("pulse_compare", exp.func, exp.pulse, pulse_compare_o);
        check_field("vel_trigger", exp.func, exp.trig, vel_trigger_o);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d replies outstanding", $time, replies_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 7;
    rx_idle_pct = 73;
    test_directed_commands();
    test_register_extremes();
    test_random_traffic();
    test_output_hold_off();
    test_sender_pause();

    wait_all_replies();
    repeat (40) @(posedge clk_i);
    $display("Run covered %0d items under %0d register settings and three idle profiles.",
             items_sent, settings_used);
    $display("%0d ticks moved the motor, %0d of them reached the set-point; %0d mismatches.",
             moving_ticks, arrivals, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
